/* hw/rtl/cdc_pkg.sv */
// Shared types, constants and calendar helper functions of the date counter.
package cdc_pkg;

  localparam int unsigned DAY_W    = 5;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned SERIAL_W = 22;
  localparam int unsigned STEP_W   = 16;

  localparam int unsigned MAX_YEAR  = 9999;
  localparam int unsigned DAYS_YEAR = 365;
  localparam int unsigned CENTURY   = 100;
  localparam int unsigned RECIP_100 = 5243;  // ceil(2^19 / 100)
  localparam int unsigned RECIP_SH  = 19;
  localparam int unsigned PROD_W    = 27;
  localparam int unsigned QUOT_W    = 8;
  localparam int unsigned REM_W     = 7;

  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [DAY_W-1:0]   DAY_LAST  = 5'd31;

  typedef struct packed {
    logic capture;
    logic ld_a;
    logic ld_b;
    logic ld_c;
    logic ld_d;
    logic step;
    logic sat_set;
  } cdc_cmd_t;

  typedef struct packed {
    logic kind;
    logic cnt_zero;
    logic at_end;
  } cdc_sts_t;

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                   input logic lp);
    logic [DAY_W-1:0] len;
    case (m) inside
      MONTH_FEB:                 len = lp ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
    logic [8:0] db;
    case (m)
      4'd2:    db = 9'd31;
      4'd3:    db = 9'd59;
      4'd4:    db = 9'd90;
      4'd5:    db = 9'd120;
      4'd6:    db = 9'd151;
      4'd7:    db = 9'd181;
      4'd8:    db = 9'd212;
      4'd9:    db = 9'd243;
      4'd10:   db = 9'd273;
      4'd11:   db = 9'd304;
      4'd12:   db = 9'd334;
      default: db = 9'd0;
    endcase
    return db;
  endfunction

endpackage

/* hw/rtl/cdc_ctrl.sv */
// Controller state machine that sequences loads and day-by-day advances.
module cdc_ctrl import cdc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  cdc_sts_t sts,
  output cdc_cmd_t cmd
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_SEL  = 8'b0000_0010,
    S_LDA  = 8'b0000_0100,
    S_LDB  = 8'b0000_1000,
    S_LDC  = 8'b0001_0000,
    S_LDD  = 8'b0010_0000,
    S_ADV  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_SEL;
        end
      end
      S_SEL:  state_nxt = sts.kind ? S_ADV : S_LDA;
      S_LDA: begin
        cmd.ld_a  = 1'b1;
        state_nxt = S_LDB;
      end
      S_LDB: begin
        cmd.ld_b  = 1'b1;
        state_nxt = S_LDC;
      end
      S_LDC: begin
        cmd.ld_c  = 1'b1;
        state_nxt = S_LDD;
      end
      S_LDD: begin
        cmd.ld_d  = 1'b1;
        state_nxt = S_OUT;
      end
      S_ADV: begin
        if (sts.cnt_zero) begin
          state_nxt = S_OUT;
        end else if (sts.at_end) begin
          cmd.sat_set = 1'b1;
          state_nxt   = S_OUT;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_OUT: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

endmodule

/* hw/rtl/cdc_dp.sv */
// Datapath holding the date, its day number and the load arithmetic.
module cdc_dp import cdc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  cdc_cmd_t            cmd,
  output cdc_sts_t            sts,
  input  logic                in_kind,
  input  logic [DAY_W-1:0]    in_load_day,
  input  logic [MONTH_W-1:0]  in_load_month,
  input  logic [YEAR_W-1:0]   in_load_year,
  input  logic [STEP_W-1:0]   in_step_count,
  output logic [DAY_W-1:0]    cur_day,
  output logic [MONTH_W-1:0]  cur_month,
  output logic [YEAR_W-1:0]   cur_year,
  output logic [SERIAL_W-1:0] day_number,
  output logic                saturated
);

  // Architectural date state.
  logic [DAY_W-1:0]    day_r, day_nxt;
  logic [MONTH_W-1:0]  month_r, month_nxt;
  logic [YEAR_W-1:0]   year_r, year_nxt;
  logic [SERIAL_W-1:0] serial_r, serial_nxt;
  logic [REM_W-1:0]    rem100_r, rem100_nxt;   // year mod 100
  logic [1:0]          cent4_r, cent4_nxt;     // (year / 100) mod 4
  logic                sat_r, sat_nxt;
  logic                kind_r;
  logic [STEP_W-1:0]   cnt_r, cnt_nxt;

  // Load working registers.
  logic [DAY_W-1:0]    ld_day_r;
  logic [MONTH_W-1:0]  ld_month_r;
  logic [YEAR_W-1:0]   ld_year_r;
  logic [PROD_W-1:0]   prod_r;
  logic [QUOT_W-1:0]   quot_r;
  logic [QUOT_W-1:0]   p100_r;
  logic [22:0]         p365_r;
  logic                leap_ld_r;

  logic [MONTH_W-1:0]  month_clamp;
  logic [YEAR_W-1:0]   year_clamp;
  logic [YEAR_W-1:0]   prev_year;
  logic [YEAR_W-1:0]   quot_x100;
  logic                div100;
  logic                leap_ld;
  logic [DAY_W-1:0]    len_ld;
  logic [DAY_W-1:0]    day_clamp;
  logic [23:0]         serial_sum;
  logic                leap_cur;
  logic [DAY_W-1:0]    len_cur;

  always_comb begin
    month_clamp = in_load_month;
    if (in_load_month == '0)     month_clamp = 4'd1;
    if (in_load_month > MONTH_DEC) month_clamp = MONTH_DEC;
    year_clamp = in_load_year;
    if (in_load_year == '0)      year_clamp = 14'd1;
    if (32'(in_load_year) > MAX_YEAR) year_clamp = YEAR_W'(MAX_YEAR);
  end

  assign prev_year = ld_year_r - 14'd1;
  assign quot_x100 = YEAR_W'(quot_r) * YEAR_W'(CENTURY);
  assign div100    = (ld_year_r == quot_x100);
  assign leap_ld   = (ld_year_r[1:0] == 2'd0) && (!div100 || (quot_r[1:0] == 2'd0));
  assign len_ld    = month_days(ld_month_r, leap_ld);

  always_comb begin
    day_clamp = ld_day_r;
    if (ld_day_r == '0)  day_clamp = 5'd1;
    if (ld_day_r > len_ld) day_clamp = len_ld;
  end

  // floor(p/400) is floor(floor(p/100)/4).
  assign serial_sum = 24'(p365_r) + 24'(prev_year >> 2) - 24'(p100_r) + 24'(p100_r >> 2)
                    + 24'(days_before(ld_month_r))
                    + 24'((ld_month_r > MONTH_FEB) && leap_ld_r) + 24'(day_r);

  assign leap_cur = (year_r[1:0] == 2'd0) && ((rem100_r != '0) || (cent4_r == 2'd0));
  assign len_cur  = month_days(month_r, leap_cur);

  always_comb begin
    day_nxt    = day_r;
    month_nxt  = month_r;
    year_nxt   = year_r;
    serial_nxt = serial_r;
    rem100_nxt = rem100_r;
    cent4_nxt  = cent4_r;
    sat_nxt    = sat_r;
    cnt_nxt    = cnt_r;
    if (cmd.capture) begin
      sat_nxt = 1'b0;
      cnt_nxt = in_step_count;
    end
    if (cmd.sat_set) sat_nxt = 1'b1;
    if (cmd.ld_c) begin
      day_nxt    = day_clamp;
      month_nxt  = ld_month_r;
      year_nxt   = ld_year_r;
      rem100_nxt = REM_W'(ld_year_r - quot_x100);
      cent4_nxt  = quot_r[1:0];
    end
    if (cmd.ld_d) serial_nxt = SERIAL_W'(serial_sum);
    if (cmd.step) begin
      cnt_nxt    = cnt_r - 16'd1;
      serial_nxt = serial_r + 22'd1;
      if (day_r >= len_cur) begin
        day_nxt = 5'd1;
        if (month_r >= MONTH_DEC) begin
          month_nxt = 4'd1;
          year_nxt  = year_r + 14'd1;
          if (rem100_r == REM_W'(CENTURY - 1)) begin
            rem100_nxt = '0;
            cent4_nxt  = cent4_r + 2'd1;
          end else begin
            rem100_nxt = rem100_r + 7'd1;
          end
        end else begin
          month_nxt = month_r + 4'd1;
        end
      end else begin
        day_nxt = day_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      day_r    <= 5'd1;
      month_r  <= 4'd1;
      year_r   <= 14'd1;
      serial_r <= 22'd1;
      rem100_r <= 7'd1;
      cent4_r  <= 2'd0;
      sat_r    <= 1'b0;
      kind_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      day_r    <= day_nxt;
      month_r  <= month_nxt;
      year_r   <= year_nxt;
      serial_r <= serial_nxt;
      rem100_r <= rem100_nxt;
      cent4_r  <= cent4_nxt;
      sat_r    <= sat_nxt;
      cnt_r    <= cnt_nxt;
      if (cmd.capture) kind_r <= in_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ld_day_r   <= in_load_day;
      ld_month_r <= month_clamp;
      ld_year_r  <= year_clamp;
    end
    if (cmd.ld_a) prod_r <= PROD_W'(ld_year_r) * PROD_W'(RECIP_100);
    if (cmd.ld_b) begin
      quot_r <= prod_r[PROD_W-1:RECIP_SH];
      p365_r <= 23'(prev_year) * 23'(DAYS_YEAR);
    end
    if (cmd.ld_c) begin
      p100_r    <= quot_r - QUOT_W'(div100);
      leap_ld_r <= leap_ld;
    end
  end

  assign sts.kind     = kind_r;
  assign sts.cnt_zero = (cnt_r == '0);
  assign sts.at_end   = (day_r == DAY_LAST) && (month_r == MONTH_DEC)
                        && (32'(year_r) >= MAX_YEAR);

  assign cur_day    = day_r;
  assign cur_month  = month_r;
  assign cur_year   = year_r;
  assign day_number = serial_r;
  assign saturated  = sat_r;

endmodule

/* hw/rtl/calendar_date_counter.sv */
// Top level of the Gregorian calendar date counter with serial day number.
//
// The block holds a date (day, month, year) and its serial day number, with
// 1.1.1 as day 1. Each input transfer is either a load (in_kind low), which
// sets the date from the load fields after clamping them into range, or an
// advance (in_kind high), which moves the date forward by in_step_count days.
// Every input transfer yields exactly one output transfer carrying the date
// and day number after the item, and out_saturated when an advance hit
// 31.12 of the last year before it had used all of its steps.
// One item is in service at a time: in_stall is high from the input
// transfer until the result has been taken. For a load, the controller
// passes through S_SEL and the load states S_LDA, S_LDB, S_LDC and S_LDD,
// working out the day number with constant multiplications and then one
// wide sum. For an advance, the day counter walks one day per cycle until
// in_step_count days are used; a saturating advance stops early.
// While the receiver holds out_stall high the result stays on the out_
// ports unchanged and no new item is taken.
// After reset (rst_n low at a clock edge) the date is 1.1.1, day number 1.
module calendar_date_counter import cdc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_kind,
  input  logic [DAY_W-1:0]    in_load_day,
  input  logic [MONTH_W-1:0]  in_load_month,
  input  logic [YEAR_W-1:0]   in_load_year,
  input  logic [STEP_W-1:0]   in_step_count,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [DAY_W-1:0]    out_cur_day,
  output logic [MONTH_W-1:0]  out_cur_month,
  output logic [YEAR_W-1:0]   out_cur_year,
  output logic [SERIAL_W-1:0] out_day_number,
  output logic                out_saturated
);

  // The controller sequences each item; the datapath holds all state.
  cdc_cmd_t cmd;
  cdc_sts_t sts;

  cdc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The date registers drive the result directly; they do not change while
  // the result is waiting, so they serve as the output register.
  cdc_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_kind       (in_kind),
    .in_load_day   (in_load_day),
    .in_load_month (in_load_month),
    .in_load_year  (in_load_year),
    .in_step_count (in_step_count),
    .cur_day       (out_cur_day),
    .cur_month     (out_cur_month),
    .cur_year      (out_cur_year),
    .day_number    (out_day_number),
    .saturated     (out_saturated)
  );

endmodule

/* hw/rtl/cdc_checker.sv */
// Port-level checker for the date counter and its bind to the top level.
module cdc_checker import cdc_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [DAY_W-1:0]    out_cur_day,
  input logic [MONTH_W-1:0]  out_cur_month,
  input logic [YEAR_W-1:0]   out_cur_year,
  input logic [SERIAL_W-1:0] out_day_number,
  input logic                out_saturated
);

  // No new item is taken while a result is waiting.
  a_no_accept_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted while a result is pending");

  // An input transfer is never followed at once by another.
  a_one_in_service: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second input accepted before the first result");

  // A stalled result holds.
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_cur_day)
      && $stable(out_cur_month) && $stable(out_cur_year) && $stable(out_day_number)
      && $stable(out_saturated)))
    else $error("stalled result changed");

  // Saturation only ever reports the last representable date.
  a_sat_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |-> (out_cur_day == DAY_LAST
      && out_cur_month == MONTH_DEC && 32'(out_cur_year) == MAX_YEAR))
    else $error("saturation flagged away from the last date");

  // A reported date always has a nonzero day and year and a month from 1 to 12.
  a_date_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_cur_day != '0 && out_cur_month != '0
      && out_cur_month <= MONTH_DEC && out_cur_year != '0))
    else $error("result date out of range");

endmodule

bind calendar_date_counter cdc_checker u_cdc_checker (.*);
